// ===== rtl/core/servo_mode_sequencer_unit_assert.svh =====
// Assertion macros for the servo mode sequencer.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef SERVO_MODE_SEQUENCER_UNIT_ASSERT_SVH
`define SERVO_MODE_SEQUENCER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SMSQ_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SMSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SMSQ_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define SMSQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/smsq_pkg.sv =====
// Shared types, state codes, register indexes and pulse constants
// for the servo mode sequencer. No dependencies.
`timescale 1ns / 1ps

package smsq_pkg;

    localparam logic [2:0] ST_MANUAL        = 3'd0;
    localparam logic [2:0] ST_RESET_ALL     = 3'd1;
    localparam logic [2:0] ST_MOVE_FIRST    = 3'd2;
    localparam logic [2:0] ST_RETURN_FIRST  = 3'd3;
    localparam logic [2:0] ST_MOVE_SECOND   = 3'd4;
    localparam logic [2:0] ST_RETURN_SECOND = 3'd5;
    localparam logic [2:0] ST_VERIFY        = 3'd6;

    localparam logic [2:0] REG_DIR_LOW       = 3'd0;
    localparam logic [2:0] REG_DIR_HIGH      = 3'd1;
    localparam logic [2:0] REG_MODE_THR      = 3'd2;
    localparam logic [2:0] REG_RESET_HOLD    = 3'd3;
    localparam logic [2:0] REG_MOVE_FIRST    = 3'd4;
    localparam logic [2:0] REG_RETURN_FIRST  = 3'd5;
    localparam logic [2:0] REG_MOVE_SECOND   = 3'd6;
    localparam logic [2:0] REG_RETURN_SECOND = 3'd7;

    localparam logic [11:0] DIR_LOW_RST       = 12'd1200;
    localparam logic [11:0] DIR_HIGH_RST      = 12'd1800;
    localparam logic [11:0] MODE_THR_RST      = 12'd1500;
    localparam logic [15:0] RESET_HOLD_RST    = 16'd5000;
    localparam logic [15:0] MOVE_FIRST_RST    = 16'd5000;
    localparam logic [15:0] RETURN_FIRST_RST  = 16'd3000;
    localparam logic [15:0] MOVE_SECOND_RST   = 16'd6800;
    localparam logic [15:0] RETURN_SECOND_RST = 16'd3000;

    localparam int ANGLE_MAX   = 180;
    localparam int ANGLE_RAISE = 45;
    localparam logic [7:0] ANGLE_UP = 8'(ANGLE_RAISE);

    localparam int PULSE_LO_S0 = 106;
    localparam int PULSE_HI_S0 = 550;
    localparam int PULSE_LO_S2 = 100;
    localparam int PULSE_HI_S2 = 525;
    localparam int PULSE_LO_SX = 105;
    localparam int PULSE_HI_SX = 515;

    localparam logic [11:0] PULSE_S0_ZERO = 12'(PULSE_LO_S0);
    localparam logic [11:0] PULSE_S0_UP   =
        12'(PULSE_LO_S0 + (ANGLE_RAISE * (PULSE_HI_S0 - PULSE_LO_S0)) / ANGLE_MAX);
    localparam logic [11:0] PULSE_S2_ZERO = 12'(PULSE_LO_S2);
    localparam logic [11:0] PULSE_S2_UP   =
        12'(PULSE_LO_S2 + (ANGLE_RAISE * (PULSE_HI_S2 - PULSE_LO_S2)) / ANGLE_MAX);
    localparam logic [11:0] PULSE_SX_ZERO = 12'(PULSE_LO_SX);
    localparam logic [11:0] PULSE_SX_UP   =
        12'(PULSE_LO_SX + (ANGLE_RAISE * (PULSE_HI_SX - PULSE_LO_SX)) / ANGLE_MAX);

    typedef struct packed {
        logic [11:0] dir_low;
        logic [11:0] dir_high;
        logic [11:0] mode_thr;
        logic [15:0] reset_hold;
        logic [15:0] move_first;
        logic [15:0] return_first;
        logic [15:0] move_second;
        logic [15:0] return_second;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  st;
        logic [31:0] phase_start;
        logic [3:0]  known;
        logic [3:0]  up;
    } t_seq;

    typedef struct packed {
        logic [1:0] idx;
        logic       up;
        logic       last;
    } t_cmd;

    typedef struct packed {
        t_cmd [3:0] ent;
        logic [2:0] cnt;
    } t_emit;

    function automatic logic [11:0] pulse_of(input logic [1:0] idx, input logic up);
        logic [11:0] p_zero;
        logic [11:0] p_up;
        unique case (idx)
            2'd0: begin
                p_zero = PULSE_S0_ZERO;
                p_up   = PULSE_S0_UP;
            end
            2'd2: begin
                p_zero = PULSE_S2_ZERO;
                p_up   = PULSE_S2_UP;
            end
            default: begin
                p_zero = PULSE_SX_ZERO;
                p_up   = PULSE_SX_UP;
            end
        endcase
        return up ? p_up : p_zero;
    endfunction

endpackage

// ===== rtl/core/servo_mode_sequencer_unit.sv =====
// A tick is registered at acceptance, evaluated into a four-entry command queue once
// the queue has room, and each queued word then passes through the output register.
// Throughput, while i_stall is low: one tick per cycle, or one per result when a tick
// gives several, since the single output register drains the queue one word per cycle.
// Reset clears the sequencer to manual mode, marks all servo angles unknown,
// loads the register defaults and empties the pipeline.
`timescale 1ns / 1ps
`include "servo_mode_sequencer_unit_assert.svh"

module servo_mode_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [11:0] i_stick_x,
    input  logic [11:0] i_stick_y,
    input  logic [11:0] i_mode_switch,
    input  logic [31:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_servo_index,
    output logic [7:0]  o_servo_angle,
    output logic [11:0] o_pulse_count,
    output logic        o_last_of_tick
);

    smsq_pkg::t_cfg       r_cfg;
    smsq_pkg::t_seq       r_seq;
    smsq_pkg::t_seq       n_seq;
    smsq_pkg::t_emit      n_emit;
    logic                 r_in_vld;
    logic [11:0]          r_stick_x;
    logic [11:0]          r_stick_y;
    logic [11:0]          r_mode_switch;
    logic [31:0]          r_now_ms;
    smsq_pkg::t_cmd [3:0] r_q;
    logic [2:0]           r_q_cnt;
    logic                 r_o_vld;
    logic [1:0]           r_o_idx;
    logic [7:0]           r_o_angle;
    logic [11:0]          r_o_pulse;
    logic                 r_o_last;
    logic                 in_acc;
    logic                 out_fire;
    logic                 pop;
    logic                 tick_go;

    assign out_fire = r_o_vld && !i_stall;
    assign pop      = (!r_o_vld || out_fire) && (r_q_cnt != 3'd0);
    assign tick_go  = r_in_vld && ((r_q_cnt == 3'd0) || ((r_q_cnt == 3'd1) && pop));
    assign o_stall  = r_in_vld && !tick_go;
    assign in_acc   = i_valid && !o_stall;

    assign o_valid        = r_o_vld;
    assign o_servo_index  = r_o_idx;
    assign o_servo_angle  = r_o_angle;
    assign o_pulse_count  = r_o_pulse;
    assign o_last_of_tick = r_o_last;

    smsq_tick u_tick (
        .i_seq         (r_seq),
        .i_cfg         (r_cfg),
        .i_stick_x     (r_stick_x),
        .i_stick_y     (r_stick_y),
        .i_mode_switch (r_mode_switch),
        .i_now_ms      (r_now_ms),
        .o_seq         (n_seq),
        .o_emit        (n_emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dir_low       <= smsq_pkg::DIR_LOW_RST;
            r_cfg.dir_high      <= smsq_pkg::DIR_HIGH_RST;
            r_cfg.mode_thr      <= smsq_pkg::MODE_THR_RST;
            r_cfg.reset_hold    <= smsq_pkg::RESET_HOLD_RST;
            r_cfg.move_first    <= smsq_pkg::MOVE_FIRST_RST;
            r_cfg.return_first  <= smsq_pkg::RETURN_FIRST_RST;
            r_cfg.move_second   <= smsq_pkg::MOVE_SECOND_RST;
            r_cfg.return_second <= smsq_pkg::RETURN_SECOND_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                smsq_pkg::REG_DIR_LOW:       r_cfg.dir_low       <= i_cfg_wdata[11:0];
                smsq_pkg::REG_DIR_HIGH:      r_cfg.dir_high      <= i_cfg_wdata[11:0];
                smsq_pkg::REG_MODE_THR:      r_cfg.mode_thr      <= i_cfg_wdata[11:0];
                smsq_pkg::REG_RESET_HOLD:    r_cfg.reset_hold    <= i_cfg_wdata;
                smsq_pkg::REG_MOVE_FIRST:    r_cfg.move_first    <= i_cfg_wdata;
                smsq_pkg::REG_RETURN_FIRST:  r_cfg.return_first  <= i_cfg_wdata;
                smsq_pkg::REG_MOVE_SECOND:   r_cfg.move_second   <= i_cfg_wdata;
                smsq_pkg::REG_RETURN_SECOND: r_cfg.return_second <= i_cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (tick_go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_stick_x     <= i_stick_x;
            r_stick_y     <= i_stick_y;
            r_mode_switch <= i_mode_switch;
            r_now_ms      <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq.st          <= smsq_pkg::ST_MANUAL;
            r_seq.phase_start <= '0;
            r_seq.known       <= 4'b0000;
            r_seq.up          <= 4'b0000;
        end else if (tick_go) begin
            r_seq <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= 3'd0;
        end else if (tick_go) begin
            r_q_cnt <= n_emit.cnt;
        end else if (pop) begin
            r_q_cnt <= r_q_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_go) begin
            r_q <= n_emit.ent;
        end else if (pop) begin
            r_q <= {r_q[3], r_q[3:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (pop) begin
            r_o_vld <= 1'b1;
        end else if (out_fire) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_o_idx   <= r_q[0].idx;
            r_o_angle <= r_q[0].up ? smsq_pkg::ANGLE_UP : 8'd0;
            r_o_pulse <= smsq_pkg::pulse_of(r_q[0].idx, r_q[0].up);
            r_o_last  <= r_q[0].last;
        end
    end

    `SMSQ_ASSERT_IMPLIES(a_more_pending, r_o_vld && !r_o_last, r_q_cnt != 3'd0, "Non-final word shown with no further words queued")
    `SMSQ_ASSERT_IMPLIES(a_tick_room, tick_go, r_q_cnt <= 3'd1, "Tick evaluated while queue still holds words")
    `SMSQ_ASSERT_NEXT(a_tick_queued, tick_go && (n_emit.cnt != 3'd0), r_q_cnt != 3'd0, "Tick words were not queued")

endmodule

// ===== rtl/core/smsq_tick.sv =====
// Next-state and command list logic for one control tick.
// Depends on smsq_pkg.
`timescale 1ns / 1ps

module smsq_tick (
    input  smsq_pkg::t_seq  i_seq,
    input  smsq_pkg::t_cfg  i_cfg,
    input  logic [11:0]     i_stick_x,
    input  logic [11:0]     i_stick_y,
    input  logic [11:0]     i_mode_switch,
    input  logic [31:0]     i_now_ms,
    output smsq_pkg::t_seq  o_seq,
    output smsq_pkg::t_emit o_emit
);

    logic                 autosel;
    logic [2:0]           st0;
    logic [2:0]           st1;
    logic [31:0]          ps0;
    logic [31:0]          ps1;
    logic [31:0]          elapsed;
    logic [15:0]          hold;
    logic [2:0]           adv_st;
    logic                 timed;
    logic                 x_neg;
    logic                 x_pos;
    logic                 y_neg;
    logic                 y_pos;
    logic [3:0]           c1;
    logic [3:0]           a1;
    logic [3:0]           known1;
    logic [3:0]           up1;
    logic                 leave;
    logic [7:0]           cand;
    smsq_pkg::t_cmd [7:0] cand_cmd;
    smsq_pkg::t_emit      emit;

    always_comb begin
        autosel = i_mode_switch > i_cfg.mode_thr;
        x_neg   = i_stick_x < i_cfg.dir_low;
        x_pos   = !x_neg && (i_stick_x > i_cfg.dir_high);
        y_neg   = i_stick_y < i_cfg.dir_low;
        y_pos   = !y_neg && (i_stick_y > i_cfg.dir_high);

        if (autosel && i_seq.st == smsq_pkg::ST_MANUAL) begin
            st0 = smsq_pkg::ST_RESET_ALL;
            ps0 = i_now_ms;
        end else begin
            st0 = i_seq.st;
            ps0 = i_seq.phase_start;
        end
        elapsed = i_now_ms - ps0;

        c1     = 4'b0000;
        a1     = 4'b0000;
        hold   = '0;
        adv_st = st0;
        timed  = 1'b0;
        st1    = st0;
        ps1    = ps0;

        unique case (st0)
            smsq_pkg::ST_MANUAL: begin
                c1 = 4'b1111;
                a1 = {x_neg, x_pos, y_neg, y_pos};
            end
            smsq_pkg::ST_RESET_ALL: begin
                c1     = 4'b1111;
                timed  = 1'b1;
                hold   = i_cfg.reset_hold;
                adv_st = smsq_pkg::ST_MOVE_FIRST;
            end
            smsq_pkg::ST_MOVE_FIRST: begin
                c1     = 4'b0001;
                a1     = 4'b0001;
                timed  = 1'b1;
                hold   = i_cfg.move_first;
                adv_st = smsq_pkg::ST_RETURN_FIRST;
            end
            smsq_pkg::ST_RETURN_FIRST: begin
                c1     = 4'b0001;
                timed  = 1'b1;
                hold   = i_cfg.return_first;
                adv_st = smsq_pkg::ST_MOVE_SECOND;
            end
            smsq_pkg::ST_MOVE_SECOND: begin
                c1     = 4'b0100;
                a1     = 4'b0100;
                timed  = 1'b1;
                hold   = i_cfg.move_second;
                adv_st = smsq_pkg::ST_RETURN_SECOND;
            end
            smsq_pkg::ST_RETURN_SECOND: begin
                c1     = 4'b0100;
                timed  = 1'b1;
                hold   = i_cfg.return_second;
                adv_st = smsq_pkg::ST_VERIFY;
            end
            smsq_pkg::ST_VERIFY: begin
                c1  = 4'b1111;
                st1 = smsq_pkg::ST_RESET_ALL;
                ps1 = i_now_ms;
            end
            default: begin
                st1 = smsq_pkg::ST_MANUAL;
            end
        endcase

        if (timed && elapsed >= {16'd0, hold}) begin
            st1 = adv_st;
            ps1 = i_now_ms;
        end

        leave  = !autosel && (st1 != smsq_pkg::ST_MANUAL);
        known1 = i_seq.known | c1;
        up1    = (c1 & a1) | (~c1 & i_seq.up);

        for (int i = 0; i < 4; i++) begin
            cand[i]            = c1[i] && (!i_seq.known[i] || (i_seq.up[i] != a1[i]));
            cand[i + 4]        = leave && (!known1[i] || up1[i]);
            cand_cmd[i].idx    = 2'(i);
            cand_cmd[i].up     = a1[i];
            cand_cmd[i].last   = 1'b0;
            cand_cmd[i + 4].idx  = 2'(i);
            cand_cmd[i + 4].up   = 1'b0;
            cand_cmd[i + 4].last = 1'b0;
        end

        emit = '0;
        for (int k = 0; k < 8; k++) begin
            if (cand[k] && emit.cnt < 3'd4) begin
                emit.ent[emit.cnt[1:0]] = cand_cmd[k];
                emit.cnt = emit.cnt + 3'd1;
            end
        end
        for (int j = 0; j < 4; j++) begin
            emit.ent[j].last = (3'(j) == emit.cnt - 3'd1);
        end

        o_emit            = emit;
        o_seq.st          = leave ? smsq_pkg::ST_MANUAL : st1;
        o_seq.phase_start = ps1;
        o_seq.known       = leave ? 4'b1111 : known1;
        o_seq.up          = leave ? 4'b0000 : up1;
    end

endmodule
